>>> src/fdld_pkg.sv
// package for the long-division float divider
// holds the state type and the exponent bias constant; no dependencies
package fdld_pkg;
    localparam logic [31:0] ExpBiasAdj = 32'd136;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } fdld_state_t;
endpackage

>>> src/fdld_stream_if.sv
// valid/ready channel interface with a Width-bit generic payload (default 32)
// depends on nothing
interface fdld_stream_if #(parameter int Width = 32);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/fdld_divider.sv
// radix-2 restoring divider plus normalise and pack sequencer
// uses fdld_pkg
module fdld_divider
    import fdld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic        taken,
    output logic        busy,
    output logic        done,
    output logic [31:0] result
);
    fdld_state_t state_reg, state_next;
    logic [31:0] num_reg, num_next;
    logic [16:0] den_reg, den_next;
    logic [16:0] rem_reg, rem_next;
    logic [23:0] q_reg, q_next;
    logic [31:0] e_reg, e_next;
    logic        sign_reg, sign_next;
    logic        zero_reg, zero_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] res_reg, res_next;
    logic [17:0] trial;
    logic [31:0] packed_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        e_reg    <= e_next;
        sign_reg <= sign_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    // shared subtract: remainder shifted with next numerator bit, minus divisor
    assign trial = {rem_reg, num_reg[31]} - {1'b0, den_reg};
    assign packed_w = {sign_reg, 31'd0} | ((e_reg + ExpBiasAdj) << 23) | {9'd0, q_reg[22:0]};

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        sign_next  = sign_reg;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    num_next  = {1'b0, 1'b1, a[22:0], 7'd0}; // significand with hidden one, << 7
                    den_next  = {1'b1, b[22:7]};
                    rem_next  = '0;
                    q_next    = '0;
                    e_next    = {24'd0, a[30:23]} - {24'd0, b[30:23]};
                    sign_next = a[31] ^ b[31];
                    zero_next = (a[30:0] == 31'd0);
                    cnt_next  = 5'd31;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next = {num_reg[30:0], 1'b0};
                if (!trial[17])
                begin
                    rem_next = trial[16:0];
                    q_next   = {q_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[15:0], num_reg[31]};
                    q_next   = {q_reg[22:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_NORM:
            begin
                if (q_reg[23])
                begin
                    res_next   = zero_reg ? 32'd0 : packed_w;
                    state_next = ST_DONE;
                end
                else
                begin
                    q_next = {q_reg[22:0], 1'b0};
                    e_next = e_reg - 32'd1;
                end
            end
            ST_DONE:
            begin
                if (taken)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = res_reg;
endmodule

>>> src/float_divide_by_long_division.sv
// top level of the long-division float divider
// uses fdld_pkg, fdld_stream_if, fdld_divider
// Between input transfer and result transfer, one item goes through 32 steps of
// a shared radix-2 restoring subtractor, 9 or 10 normalising shifts and one
// pack step, then a result register that holds until transferred. The block
// takes one item at a time; in_ch.ready is high only while idle. Zero dividends
// give +0; no rounding, no special values.
module float_divide_by_long_division
    import fdld_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fdld_stream_if.sink   in_ch,
    fdld_stream_if.source out_ch
);
    logic busy, done;
    logic [31:0] result;

    fdld_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_ch.valid && !busy),
        .a      (in_ch.data[63:32]),
        .b      (in_ch.data[31:0]),
        .taken  (out_ch.ready),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    assign in_ch.ready  = !busy;
    assign out_ch.valid = done;
    assign out_ch.data  = result;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("not busy after transfer");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
        else $error("result changed while stalled");
endmodule

>>> sim/tb_top.sv
// testbench for the long-division float divider: directed and random operand pairs,
// quotient predicted in-bench and checked in order; uses fdld_pkg and fdld_stream_if
module tb_top
    import fdld_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;

    fdld_stream_if #(.Width(64)) in_ch ();
    fdld_stream_if #(.Width(32)) out_ch ();

    float_divide_by_long_division uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    localparam logic [31:0] ExpMask   = 32'h7F80_0000;
    localparam logic [31:0] FracMask  = 32'h007F_FFFF;
    localparam logic [31:0] HiddenOne = 32'h0080_0000;
    localparam logic [31:0] SignMask  = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] dividend_bits;
        logic [31:0] divisor_bits;
    } operands_t;

    operands_t   pending_ops[$];
    logic [31:0] expected_quotients[$];
    int          mismatches = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    bit          stimulus_done;
    bit          calm;
    bit          in_taken;

    function automatic logic [31:0] approx_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ea;
        logic [31:0] eb;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] q;
        logic [31:0] e;
        int          shifts;
        ea = (a & ExpMask) >> 23;
        eb = (b & ExpMask) >> 23;
        num = ((a & FracMask) | HiddenOne) << 7;
        den = ((b & FracMask) | HiddenOne) >> 7;
        if ((a & ~SignMask) == 32'd0)
            return 32'd0;
        q = num / den;
        e = ea - eb;
        shifts = 0;
        while ((q & HiddenOne) == 32'd0 && q != 32'd0 && shifts < 24)
        begin
            q = q << 1;
            e = e - 32'd1;
            shifts++;
        end
        e = (e + ExpBiasAdj) << 23;
        return ((a ^ b) & SignMask) | e | (q & FracMask);
    endfunction

    function automatic logic [31:0] make_float(logic s, logic [7:0] ex, logic [22:0] fr);
        return {s, ex, fr};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // stimulus
    initial
    begin
        operands_t op;
        logic [7:0] ex;
        stimulus_done = 1'b0;
        // zero dividends, both signs
        pending_ops.push_back('{32'h0000_0000, 32'h3F80_0000});
        pending_ops.push_back('{32'h8000_0000, 32'hC000_0000});
        pending_ops.push_back('{32'h8000_0000, 32'h0000_0000});
        // zero divisor
        pending_ops.push_back('{32'h3F80_0000, 32'h0000_0000});
        pending_ops.push_back('{32'hC0A0_0000, 32'h8000_0000});
        // denormals
        pending_ops.push_back('{32'h0000_0001, 32'h3F80_0000});
        pending_ops.push_back('{32'h3F80_0000, 32'h007F_FFFF});
        pending_ops.push_back('{32'h807F_FFFF, 32'h0000_0001});
        // infinities and nan
        pending_ops.push_back('{32'h7F80_0000, 32'h3F80_0000});
        pending_ops.push_back('{32'h3F80_0000, 32'hFF80_0000});
        pending_ops.push_back('{32'h7FFF_FFFF, 32'hFFC0_0001});
        // fraction extremes
        pending_ops.push_back('{32'h3FFF_FFFF, 32'h3F80_0000});
        pending_ops.push_back('{32'h3F80_0000, 32'h3FFF_FFFF});
        pending_ops.push_back('{32'h3FFF_FFFF, 32'h3FFF_FFFF});
        // exponent wrap both ways
        pending_ops.push_back('{32'h7F7F_FFFF, 32'h0000_0000});
        pending_ops.push_back('{32'h0080_0000, 32'h7F7F_FFFF});
        pending_ops.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        pending_ops.push_back('{32'h4049_0FDB, 32'h402D_F854});
        for (int i = 0; i < 1300; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                op.dividend_bits = $urandom;
                op.divisor_bits = $urandom;
            end
            else
            begin
                ex = 8'($urandom_range(90, 165));
                op.dividend_bits = make_float(1'($urandom_range(0, 1)), ex, 23'($urandom));
                ex = 8'($urandom_range(90, 165));
                op.divisor_bits = make_float(1'($urandom_range(0, 1)), ex, 23'($urandom));
            end
            if ($urandom_range(0, 40) == 0)
                op.dividend_bits = op.dividend_bits & SignMask;
            pending_ops.push_back(op);
        end
        stimulus_done = 1'b1;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            out_ch.ready <= 1'b0;
            calm <= 1'b0;
        end
        else
        begin
            calm <= (sent_count >= 500 && sent_count < 700);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
            if (!in_ch.valid || in_taken)
            begin
                if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 18))
                begin
                    in_ch.data <= pending_ops.pop_front();
                    in_ch.valid <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // input transfer: predict, and tell the driver the item is gone
    always @(posedge clk)
    begin
        operands_t op;
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            op = in_ch.data;
            expected_quotients.push_back(approx_quotient(op.dividend_bits, op.divisor_bits));
            sent_count <= sent_count + 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_quotients.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected quotient transfer: %h", out_ch.data);
            end
            else
            begin
                want = expected_quotients.pop_front();
                checked_count++;
                if (out_ch.data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("quotient_bits mismatch: expected %h actual %h",
                                 want, out_ch.data);
                end
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_ops.size() == 0 && !in_ch.valid && expected_quotients.size() == 0);
        repeat (100) @(posedge clk);
        $display("%0d operand pairs divided, %0d quotients checked, %0d mismatches",
                 sent_count, checked_count, mismatches);
        if (mismatches == 0 && expected_quotients.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d quotients outstanding", expected_quotients.size());
        $display("FAILURE");
        $finish;
    end
endmodule

>>> float_divide_by_long_division.f
src/fdld_pkg.sv
src/fdld_stream_if.sv
src/fdld_divider.sv
src/float_divide_by_long_division.sv
sim/tb_top.sv
